[rtl/brfb_pkg.sv]
// ----------------------------------------------------------------------------
// brfb_pkg
// Shared codes, widths and the job record passed from the front to the back
// of the byte ring FIFO.
// ----------------------------------------------------------------------------
package brfb_pkg;

	localparam int ActionW  = 2;
	localparam int CountW   = 4;
	localparam int ByteW    = 8;
	localparam int LevelW   = 11;
	localparam int NumBytes = 8;
	localparam int AddrMaxW = 16;

	localparam logic [ActionW-1:0] ACT_PUT   = 2'd0;
	localparam logic [ActionW-1:0] ACT_GET   = 2'd1;
	localparam logic [ActionW-1:0] ACT_QUERY = 2'd2;

	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REFUSE = 1'b1;

	// one queued job: either a single result beat or a stream of read beats
	typedef struct packed {
		logic                stream;
		logic                status;
		logic [CountW-1:0]   done;
		logic [LevelW-1:0]   level;
		logic [AddrMaxW-1:0] addr;
		logic [CountW-1:0]   count;
	} job_t;

endpackage

[rtl/brfb_store.sv]
// ----------------------------------------------------------------------------
// brfb_store
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module brfb_store #(
	parameter int AW = 10
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [brfb_pkg::ByteW-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [brfb_pkg::ByteW-1:0] rdata_q
);

	logic [brfb_pkg::ByteW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

[rtl/brfb_queue.sv]
// ----------------------------------------------------------------------------
// brfb_queue
// Two-entry job queue between the classifying front and the result back.
// ----------------------------------------------------------------------------
module brfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brfb_pkg::job_t din,
	input  logic           pop,
	output brfb_pkg::job_t dout,
	output logic           q_full,
	output logic           q_empty
);

	brfb_pkg::job_t slot_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     used_q;
	logic           do_push;
	logic           do_pop;

	assign q_full  = (used_q == 2'd2);
	assign q_empty = (used_q == 2'd0);
	assign do_push = push && !q_full;
	assign do_pop  = pop && !q_empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   used_q <= used_q + 2'd1;
				2'b01:   used_q <= used_q - 2'd1;
				default: used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/brfb_front.sv]
// ----------------------------------------------------------------------------
// brfb_front
// Takes one operation, checks it against the counters, updates them, queues
// the job for the back and writes put bytes into the store one a cycle.
// ----------------------------------------------------------------------------
module brfb_front #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [brfb_pkg::ActionW-1:0]  action,
	input  logic [brfb_pkg::CountW-1:0]   count,
	input  logic [brfb_pkg::ByteW-1:0]    bytes_in [brfb_pkg::NumBytes],
	output logic                          job_push,
	output brfb_pkg::job_t                job,
	input  logic                          q_full,
	input  logic                          q_empty,
	input  logic                          back_busy,
	output logic                          we,
	output logic [$clog2(DEPTH)-1:0]      waddr,
	output logic [brfb_pkg::ByteW-1:0]    wdata
);

	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = AW + 1;
	localparam int CmpW       = CW + brfb_pkg::CountW;
	localparam int BurstLimit = (MAX_BURST < brfb_pkg::NumBytes) ? MAX_BURST
		: brfb_pkg::NumBytes;
	localparam int IdxW       = $clog2(brfb_pkg::NumBytes);

	typedef enum logic [2:0] {
		FS_IDLE     = 3'b001,
		FS_CLASSIFY = 3'b010,
		FS_WRITE    = 3'b100
	} fstate_t;

	fstate_t                            state_q;
	logic [brfb_pkg::ActionW-1:0]       act_q;
	logic [brfb_pkg::CountW-1:0]        cnt_q;
	logic [brfb_pkg::ByteW-1:0]         bytes_q [brfb_pkg::NumBytes];
	logic [CW-1:0]                      wc_q;
	logic [CW-1:0]                      rc_q;
	logic [AW-1:0]                      wptr_q;
	logic [IdxW-1:0]                    idx_q;
	logic [brfb_pkg::CountW-1:0]        rem_q;

	logic [CW-1:0]                      fill;
	logic [CW-1:0]                      free_sp;
	logic [CW-1:0]                      wc_n;
	logic [CW-1:0]                      rc_n;
	logic [CW-1:0]                      rc_adv;
	logic [CW-1:0]                      level_n;
	logic                               over;
	logic                               go_write;
	logic                               need_idle;
	logic                               can_go;

	assign full    = (state_q != FS_IDLE);
	assign fill    = wc_q - rc_q;
	assign free_sp = CW'(DEPTH) - fill;
	assign over    = (cnt_q > brfb_pkg::CountW'(BurstLimit));
	assign rc_adv  = rc_q + CW'(cnt_q);
	assign level_n = wc_n - rc_n;

	always_comb begin
		job        = '0;
		job.status = brfb_pkg::ST_REFUSE;
		job.addr   = brfb_pkg::AddrMaxW'(rc_q[AW-1:0]);
		job.count  = cnt_q;
		wc_n       = wc_q;
		rc_n       = rc_q;
		go_write   = 1'b0;
		need_idle  = 1'b0;
		unique case (act_q)
			brfb_pkg::ACT_PUT: begin
				if (!over && (CmpW'(cnt_q) <= CmpW'(free_sp))) begin
					job.status = brfb_pkg::ST_OK;
					job.done   = cnt_q;
					wc_n       = wc_q + CW'(cnt_q);
					go_write   = (cnt_q != '0);
					need_idle  = 1'b1;
				end
			end
			brfb_pkg::ACT_GET: begin
				if (!over && (CmpW'(cnt_q) <= CmpW'(fill))) begin
					job.status = brfb_pkg::ST_OK;
					job.done   = cnt_q;
					job.stream = (cnt_q != '0);
					rc_n       = rc_adv;
				end
				// store empty after a get: both counters restart at zero
				if (wc_n == rc_n) begin
					wc_n = '0;
					rc_n = '0;
				end
			end
			brfb_pkg::ACT_QUERY: begin
				job.status = brfb_pkg::ST_OK;
			end
			default: begin
			end
		endcase
		job.level = brfb_pkg::LevelW'(level_n);
	end

	// a put must not overwrite bytes that an earlier get has yet to read
	assign can_go   = !q_full && (!need_idle || (q_empty && !back_busy));
	assign job_push = (state_q == FS_CLASSIFY) && can_go;

	assign we    = (state_q == FS_WRITE);
	assign waddr = wptr_q;
	assign wdata = bytes_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			wc_q    <= '0;
			rc_q    <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (push) begin
						state_q <= FS_CLASSIFY;
					end
				end
				FS_CLASSIFY: begin
					if (can_go) begin
						wc_q    <= wc_n;
						rc_q    <= rc_n;
						state_q <= go_write ? FS_WRITE : FS_IDLE;
					end
				end
				FS_WRITE: begin
					if (rem_q == brfb_pkg::CountW'(1)) begin
						state_q <= FS_IDLE;
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == FS_IDLE) && push) begin
			act_q   <= action;
			cnt_q   <= count;
			bytes_q <= bytes_in;
		end
		if (job_push) begin
			wptr_q <= wc_q[AW-1:0];
			idx_q  <= '0;
			rem_q  <= cnt_q;
		end else if (state_q == FS_WRITE) begin
			wptr_q <= wptr_q + AW'(1);
			idx_q  <= idx_q + IdxW'(1);
			rem_q  <= rem_q - brfb_pkg::CountW'(1);
		end
	end

endmodule

[rtl/brfb_back.sv]
// ----------------------------------------------------------------------------
// brfb_back
// Turns queued jobs into result beats: one beat per cycle unless pop holds the
// output, reading the store for get bytes, through a read stage and an output register.
// ----------------------------------------------------------------------------
module brfb_back #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brfb_pkg::job_t                job,
	input  logic                          q_empty,
	output logic                          q_pop,
	output logic                          back_busy,
	output logic                          re,
	output logic [$clog2(DEPTH)-1:0]      raddr,
	input  logic [brfb_pkg::ByteW-1:0]    rdata,
	output logic                          empty,
	input  logic                          pop,
	output logic                          status,
	output logic [brfb_pkg::CountW-1:0]   done_count,
	output logic [brfb_pkg::ByteW-1:0]    out_byte,
	output logic                          last,
	output logic [brfb_pkg::LevelW-1:0]   level
);

	localparam int AW = $clog2(DEPTH);

	logic                          active_q;
	brfb_pkg::job_t                job_q;
	logic [AW-1:0]                 addr_q;
	logic [brfb_pkg::CountW-1:0]   rem_q;

	logic                          valid_s1;
	logic                          status_s1;
	logic [brfb_pkg::CountW-1:0]   done_s1;
	logic [brfb_pkg::LevelW-1:0]   level_s1;
	logic                          last_s1;
	logic                          rd_s1;

	logic                          out_valid_q;
	logic                          status_q;
	logic [brfb_pkg::CountW-1:0]   done_q;
	logic [brfb_pkg::ByteW-1:0]    byte_q;
	logic                          last_q;
	logic [brfb_pkg::LevelW-1:0]   level_q;

	logic                          move;
	logic                          s1_free;
	logic                          issue;
	logic                          issue_last;

	assign move       = valid_s1 && (!out_valid_q || pop);
	assign s1_free    = !valid_s1 || move;
	assign issue      = active_q && s1_free;
	assign issue_last = job_q.stream ? (rem_q == brfb_pkg::CountW'(1)) : 1'b1;
	assign q_pop      = !q_empty && (!active_q || (issue && issue_last));
	assign back_busy  = active_q;
	assign re         = issue && job_q.stream;
	assign raddr      = addr_q;

	assign empty      = !out_valid_q;
	assign status     = status_q;
	assign done_count = done_q;
	assign out_byte   = byte_q;
	assign last       = last_q;
	assign level      = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (issue && issue_last) begin
				active_q <= 1'b0;
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q  <= job;
			addr_q <= job.addr[AW-1:0];
			rem_q  <= job.count;
		end else if (issue) begin
			addr_q <= addr_q + AW'(1);
			rem_q  <= rem_q - brfb_pkg::CountW'(1);
		end
		if (issue) begin
			status_s1 <= job_q.status;
			done_s1   <= job_q.done;
			level_s1  <= job_q.level;
			last_s1   <= issue_last;
			rd_s1     <= job_q.stream;
		end
		if (move) begin
			status_q <= status_s1;
			done_q   <= done_s1;
			byte_q   <= rd_s1 ? rdata : '0;
			last_q   <= last_s1;
			level_q  <= level_s1;
		end
	end

endmodule

[rtl/byte_ring_fifo_block_transfer_core.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_transfer_core
// Byte FIFO on a power-of-two ring store with burst put, burst get and fill
// level query.
// ----------------------------------------------------------------------------
// An operation is taken when push is high and full is low. The front first
// checks the operation against the counters, then a put writes its bytes one
// after another on the store's single write port; full stays high until the
// front is back in idle. A put also waits until every earlier get has finished
// reading the store. Results leave through the back at one beat per cycle while
// pop stays high, one beat per get byte and a single beat for everything else;
// the first beat of an operation passes the front, the job queue, the back's job
// register, the read stage and the output register. Results wait in an output
// register while the front already works on the next operation. There is no
// clearing pass after reset.
module byte_ring_fifo_block_transfer_core #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [brfb_pkg::ActionW-1:0]  action,
	input  logic [brfb_pkg::CountW-1:0]   count,
	input  logic [brfb_pkg::ByteW-1:0]    byte0,
	input  logic [brfb_pkg::ByteW-1:0]    byte1,
	input  logic [brfb_pkg::ByteW-1:0]    byte2,
	input  logic [brfb_pkg::ByteW-1:0]    byte3,
	input  logic [brfb_pkg::ByteW-1:0]    byte4,
	input  logic [brfb_pkg::ByteW-1:0]    byte5,
	input  logic [brfb_pkg::ByteW-1:0]    byte6,
	input  logic [brfb_pkg::ByteW-1:0]    byte7,
	output logic                          empty,
	input  logic                          pop,
	output logic                          status,
	output logic [brfb_pkg::CountW-1:0]   done_count,
	output logic [brfb_pkg::ByteW-1:0]    out_byte,
	output logic                          last,
	output logic [brfb_pkg::LevelW-1:0]   level
);

	localparam int AW = $clog2(DEPTH);

	logic [brfb_pkg::ByteW-1:0] bytes_in [brfb_pkg::NumBytes];
	brfb_pkg::job_t             job_in;
	brfb_pkg::job_t             job_out;
	logic                       job_push;
	logic                       q_pop;
	logic                       q_full;
	logic                       q_empty;
	logic                       back_busy;
	logic                       we;
	logic [AW-1:0]              waddr;
	logic [brfb_pkg::ByteW-1:0] wdata;
	logic                       re;
	logic [AW-1:0]              raddr;
	logic [brfb_pkg::ByteW-1:0] rdata;

	assign bytes_in[0] = byte0;
	assign bytes_in[1] = byte1;
	assign bytes_in[2] = byte2;
	assign bytes_in[3] = byte3;
	assign bytes_in[4] = byte4;
	assign bytes_in[5] = byte5;
	assign bytes_in[6] = byte6;
	assign bytes_in[7] = byte7;

	brfb_front #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.count     (count),
		.bytes_in  (bytes_in),
		.job_push  (job_push),
		.job       (job_in),
		.q_full    (q_full),
		.q_empty   (q_empty),
		.back_busy (back_busy),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	brfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.din     (job_in),
		.pop     (q_pop),
		.dout    (job_out),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	brfb_store #(
		.AW (AW)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (re),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	brfb_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_out),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.back_busy  (back_busy),
		.re         (re),
		.raddr      (raddr),
		.rdata      (rdata),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.done_count (done_count),
		.out_byte   (out_byte),
		.last       (last),
		.level      (level)
	);

endmodule

[rtl/brfb_checker.sv]
// ----------------------------------------------------------------------------
// brfb_checker
// Port-level checks on the result side of the byte ring FIFO.
// ----------------------------------------------------------------------------
module brfb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic                          status,
	input logic [brfb_pkg::CountW-1:0]   done_count,
	input logic [brfb_pkg::ByteW-1:0]    out_byte,
	input logic                          last,
	input logic [brfb_pkg::LevelW-1:0]   level
);

	// a waiting beat stays
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result beat dropped while stalled");

	// a stalled beat holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(status) && $stable(done_count)
			&& $stable(out_byte) && $stable(last) && $stable(level)))
		else $error("stalled result beat changed");

	// a refusal is a single bare beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (last && (done_count == '0) && (out_byte == '0)))
		else $error("refused beat carries data");

	// only an accepted get with bytes left goes on past one beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (!status && (done_count != '0)))
		else $error("non-final beat outside a get stream");

	// within a get stream count and level hold from beat to beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=>
			(empty || ((done_count == $past(done_count)) && (level == $past(level)))))
		else $error("get stream beats disagree");

endmodule

bind byte_ring_fifo_block_transfer_core brfb_checker u_brfb_checker (.*);

[tb/byte_ring_fifo_block_transfer_core_tb.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_block_transfer_core_tb
// Self-checking bench for the byte ring FIFO. A short table of directed
// operations covers the field extremes, refusals, the unused action and the
// counter clear on empty. Random traffic follows: it fills the store, hovers
// near full so the ring wraps and puts are refused for lack of space, then
// drains it. Every result beat is compared field by field against an
// in-bench copy of the FIFO. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module byte_ring_fifo_block_transfer_core_tb;
	import brfb_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int BURST_MAX   = 8;
	localparam int RAND_OPS    = 375;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	localparam logic [ActionW-1:0] ACT_BAD = 2'd3;

	localparam int MODE_FILL  = 0;
	localparam int MODE_HOVER = 1;
	localparam int MODE_DRAIN = 2;

	typedef struct packed {
		logic              status;
		logic [CountW-1:0] done;
		logic [ByteW-1:0]  data;
		logic              last;
		logic [LevelW-1:0] level;
	} beat_t;

	typedef struct {
		logic [ActionW-1:0]               act;
		logic [CountW-1:0]                cnt;
		logic [NumBytes-1:0][ByteW-1:0]   bytes;
		bit                               typed;
		beat_t                            want;
	} op_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [ActionW-1:0]   action = ACT_PUT;
	logic [CountW-1:0]    count = '0;
	logic [ByteW-1:0]     byte0 = '0;
	logic [ByteW-1:0]     byte1 = '0;
	logic [ByteW-1:0]     byte2 = '0;
	logic [ByteW-1:0]     byte3 = '0;
	logic [ByteW-1:0]     byte4 = '0;
	logic [ByteW-1:0]     byte5 = '0;
	logic [ByteW-1:0]     byte6 = '0;
	logic [ByteW-1:0]     byte7 = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 status;
	logic [CountW-1:0]    done_count;
	logic [ByteW-1:0]     out_byte;
	logic                 last;
	logic [LevelW-1:0]    level;

	// fifo copy
	logic [ByteW-1:0]     ring [DEPTH];
	logic [LevelW-1:0]    wr_ptr = '0;
	logic [LevelW-1:0]    rd_ptr = '0;
	beat_t                op_beats [NumBytes];
	int                   op_nbeats;

	beat_t                due_q [$];
	op_t                  plan [$];
	bit                   typed_now = 1'b0;
	beat_t                typed_want = '0;
	bit                   calm = 1'b0;
	bit                   op_taken = 1'b0;
	bit                   stim_done = 1'b0;
	int                   errors = 0;
	int                   quiet = 0;

	byte_ring_fifo_block_transfer_core #(
		.DEPTH(DEPTH),
		.MAX_BURST(BURST_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.count(count),
		.byte0(byte0),
		.byte1(byte1),
		.byte2(byte2),
		.byte3(byte3),
		.byte4(byte4),
		.byte5(byte5),
		.byte6(byte6),
		.byte7(byte7),
		.empty(empty),
		.pop(pop),
		.status(status),
		.done_count(done_count),
		.out_byte(out_byte),
		.last(last),
		.level(level)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [LevelW-1:0] ring_fill();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic beat_t mk_beat(logic st, logic [CountW-1:0] d, logic [ByteW-1:0] v,
			logic l);
		beat_t b;
		b.status = st;
		b.done   = d;
		b.data   = v;
		b.last   = l;
		b.level  = ring_fill();
		return b;
	endfunction

	task automatic fifo_op(input logic [ActionW-1:0] act, input logic [CountW-1:0] cnt,
			input logic [NumBytes-1:0][ByteW-1:0] bytes);
		logic [ByteW-1:0]  got [NumBytes];
		logic [LevelW-1:0] a;
		bit                refused;
		op_nbeats = 1;
		case (act)
			ACT_PUT: begin
				if (cnt > BURST_MAX || cnt > DEPTH - ring_fill()) begin
					op_beats[0] = mk_beat(ST_REFUSE, 0, 0, 1'b1);
				end else begin
					for (int i = 0; i < cnt; i++) begin
						a = wr_ptr + LevelW'(i);
						ring[int'(a) % DEPTH] = bytes[i];
					end
					wr_ptr = wr_ptr + cnt;
					op_beats[0] = mk_beat(ST_OK, cnt, 0, 1'b1);
				end
			end
			ACT_GET: begin
				refused = (cnt > BURST_MAX) || (cnt > ring_fill());
				if (!refused) begin
					for (int i = 0; i < cnt; i++) begin
						a = rd_ptr + LevelW'(i);
						got[i] = ring[int'(a) % DEPTH];
					end
					rd_ptr = rd_ptr + cnt;
				end
				// counters restart whenever a get sees the store empty
				if (wr_ptr == rd_ptr) begin
					wr_ptr = '0;
					rd_ptr = '0;
				end
				if (refused) begin
					op_beats[0] = mk_beat(ST_REFUSE, 0, 0, 1'b1);
				end else if (cnt == 0) begin
					op_beats[0] = mk_beat(ST_OK, 0, 0, 1'b1);
				end else begin
					for (int i = 0; i < cnt; i++)
						op_beats[i] = mk_beat(ST_OK, cnt, got[i], i == cnt - 1);
					op_nbeats = cnt;
				end
			end
			ACT_QUERY: begin
				op_beats[0] = mk_beat(ST_OK, 0, 0, 1'b1);
			end
			default: begin
				op_beats[0] = mk_beat(ST_REFUSE, 0, 0, 1'b1);
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			errors++;
		end
	endtask

	task automatic add_row(input logic [ActionW-1:0] act, input logic [CountW-1:0] cnt,
			input logic [63:0] bytes, input bit typed, input logic st,
			input logic [CountW-1:0] d, input logic [LevelW-1:0] lvl);
		op_t op;
		op.act   = act;
		op.cnt   = cnt;
		op.bytes = bytes;
		op.typed = typed;
		op.want  = '{st, d, 8'h00, 1'b1, lvl};
		plan.push_back(op);
	endtask

	task automatic send_op(input op_t op);
		while (!calm && $urandom_range(99) < 7) begin
			push <= 1'b0;
			@(negedge clk);
		end
		action     <= op.act;
		count      <= op.cnt;
		byte0      <= op.bytes[0];
		byte1      <= op.bytes[1];
		byte2      <= op.bytes[2];
		byte3      <= op.bytes[3];
		byte4      <= op.bytes[4];
		byte5      <= op.bytes[5];
		byte6      <= op.bytes[6];
		byte7      <= op.bytes[7];
		typed_now  <= op.typed;
		typed_want <= op.want;
		push       <= 1'b1;
		@(negedge clk);
		while (!op_taken) @(negedge clk);
	endtask

	always @(negedge clk) begin
		pop <= arst_n && (calm || $urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		beat_t seen;
		beat_t want;
		if (arst_n) begin
			op_taken = push && !full;
			if (push && !full) begin
				fifo_op(action, count, {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0});
				if (typed_now)
					due_q.push_back(typed_want);
				else
					for (int i = 0; i < op_nbeats; i++) due_q.push_back(op_beats[i]);
			end
			if (pop && !empty) begin
				seen = '{status, done_count, out_byte, last, level};
				if (due_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %p", $time, seen);
					errors++;
				end else begin
					want = due_q.pop_front();
					check_field("status", want.status, seen.status);
					check_field("done_count", want.done, seen.done);
					check_field("out_byte", want.data, seen.data);
					check_field("last", want.last, seen.last);
					check_field("level", want.level, seen.level);
				end
			end
			if ((push && !full) || (pop && !empty) || (stim_done && due_q.size() == 0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("byte_ring_fifo_block_transfer_core_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		op_t op;
		int  mode;
		int  hover_left;
		int  r;
		int  put_pct;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_row(ACT_QUERY, 0, 64'h0, 1, ST_OK, 0, 0);
		add_row(ACT_GET, 0, 64'h0, 1, ST_OK, 0, 0);
		add_row(ACT_GET, 1, 64'h0, 1, ST_REFUSE, 0, 0);
		add_row(ACT_PUT, 0, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 0, 0);
		add_row(ACT_PUT, 8, 64'h00FF_55AA_8001_FE7F, 1, ST_OK, 8, 8);
		add_row(ACT_PUT, 9, 64'h0, 1, ST_REFUSE, 0, 8);
		add_row(ACT_PUT, 15, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_REFUSE, 0, 8);
		add_row(ACT_BAD, 8, 64'h0, 1, ST_REFUSE, 0, 8);
		add_row(ACT_GET, 9, 64'h0, 1, ST_REFUSE, 0, 8);
		add_row(ACT_GET, 15, 64'h0, 1, ST_REFUSE, 0, 8);
		add_row(ACT_GET, 3, 64'h0, 0, 0, 0, 0);
		add_row(ACT_QUERY, 0, 64'h0, 1, ST_OK, 0, 5);
		add_row(ACT_GET, 6, 64'h0, 1, ST_REFUSE, 0, 5);
		add_row(ACT_PUT, 1, 64'h0000_0000_0000_00FF, 0, 0, 0, 0);
		add_row(ACT_GET, 6, 64'h0, 0, 0, 0, 0);
		add_row(ACT_QUERY, 0, 64'h0, 1, ST_OK, 0, 0);
		add_row(ACT_PUT, 8, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK, 8, 8);
		add_row(ACT_GET, 8, 64'h0, 0, 0, 0, 0);
		add_row(ACT_PUT, 8, 64'h0, 1, ST_OK, 8, 8);
		add_row(ACT_PUT, 7, 64'h1122_3344_5566_7788, 0, 0, 0, 0);
		add_row(ACT_GET, 1, 64'h0, 0, 0, 0, 0);
		add_row(ACT_GET, 8, 64'h0, 0, 0, 0, 0);
		add_row(ACT_GET, 6, 64'h0, 0, 0, 0, 0);
		add_row(ACT_GET, 0, 64'h0, 1, ST_OK, 0, 0);
		add_row(ACT_BAD, 0, 64'h0, 1, ST_REFUSE, 0, 0);
		foreach (plan[i]) send_op(plan[i]);

		// fill, hover near full so the ring wraps, then drain
		mode = MODE_FILL;
		hover_left = 0;
		for (int k = 0; k < RAND_OPS; k++) begin
			calm <= (k >= 100 && k < 180);
			if (mode == MODE_FILL && ring_fill() >= 1000) begin
				mode = MODE_HOVER;
				hover_left = 60;
			end else if (mode == MODE_HOVER) begin
				hover_left--;
				if (hover_left == 0) mode = MODE_DRAIN;
			end else if (mode == MODE_DRAIN && ring_fill() == 0) begin
				mode = MODE_FILL;
			end
			put_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_HOVER) ? 50 : 10;
			r = $urandom_range(99);
			if (r < 3)
				op.act = ACT_BAD;
			else if (r < 8)
				op.act = ACT_QUERY;
			else if ($urandom_range(99) < put_pct)
				op.act = ACT_PUT;
			else
				op.act = ACT_GET;
			r = $urandom_range(99);
			if (r < 5)
				op.cnt = $urandom_range(15, 9);
			else if (r < 10)
				op.cnt = 0;
			else if ((mode == MODE_FILL && op.act == ACT_PUT) ||
					(mode == MODE_DRAIN && op.act == ACT_GET))
				op.cnt = $urandom_range(8, 6);
			else
				op.cnt = $urandom_range(8, 1);
			for (int i = 0; i < NumBytes; i++) op.bytes[i] = $urandom;
			op.typed = 1'b0;
			op.want  = '0;
			send_op(op);
		end
		push <= 1'b0;
		calm <= 1'b0;
		stim_done = 1'b1;

		while (due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("byte_ring_fifo_block_transfer_core_tb OK");
		else
			$display("byte_ring_fifo_block_transfer_core_tb NOT OK");
		$finish;
	end

endmodule
